### design/ist_pkg.sv
// Package for the interval set tracker: command, status and state codes,
// and default sizes. No dependencies.
`default_nettype none
package ist_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int IN_COORD_W        = 32;
  localparam int COUNT_W           = 7;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_SPLIT,
    ST_END,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

### design/ist_mem.sv
// Interval table memory: one write port and one read port, registered read.
// Holds both banks of the table; no package dependency.
`default_nettype none
module ist_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### design/ist_ctrl.sv
// Sequencer and datapath of the interval set tracker. Streams the live bank
// of the table through the request's operation into the other bank.
// Depends on ist_pkg and drives one ist_mem.
`default_nettype none
module ist_ctrl #(
  parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_WIDTH   = ist_pkg::COORD_WIDTH_DEF,
  localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
  localparam int AW = IW + 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire ist_pkg::cmd_t                     in_cmd,
  input  wire logic [ist_pkg::IN_COORD_W-1:0]    in_range_left,
  input  wire logic [ist_pkg::IN_COORD_W-1:0]    in_range_right,
  output logic                                   out_valid,
  output logic                                   out_covered,
  output ist_pkg::status_t                       out_status,
  output logic [ist_pkg::COUNT_W-1:0]            out_entry_count,
  output logic                                   mem_wr_en,
  output logic [AW-1:0]                          mem_wr_addr,
  output logic [2*COORD_WIDTH-1:0]               mem_wr_data,
  output logic                                   mem_rd_en,
  output logic [AW-1:0]                          mem_rd_addr,
  input  wire logic [2*COORD_WIDTH-1:0]          mem_rd_data
);
  import ist_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int CNTW = $clog2(MAX_INTERVALS + 2);
  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_INTERVALS);

  state_t          state_r, state_nxt;
  cmd_t            cmd_r;
  logic            bad_r, ins_r, cov_r, bank_r;
  logic [CW-1:0]   lo_r, hi_r, mlo_r, mhi_r, plo_r, phi_r;
  logic [CNTW-1:0] rd_idx_r, wr_cnt_r, total_r;
  logic            out_valid_r, out_covered_r;
  status_t         out_status_r;

  logic [CW+IN_COORD_W-1:0] left_ext, right_ext;
  logic [CW-1:0]   in_lo, in_hi, rs, re;
  logic            in_bad;
  logic            ev_emit, ev_split, ev_absorb;
  logic [CW-1:0]   ev_s, ev_e, ev_ps, ev_pe;
  logic            emit;
  logic [CW-1:0]   emit_s, emit_e;
  logic            over;
  logic [CNTW+COUNT_W-1:0] count_ext;

  // Only the low COORD_WIDTH bits of each coordinate are significant.
  assign left_ext  = {{CW{1'b0}}, in_range_left};
  assign right_ext = {{CW{1'b0}}, in_range_right};
  assign in_lo     = left_ext[CW-1:0];
  assign in_hi     = right_ext[CW-1:0];
  assign in_bad    = (in_cmd != CMD_NONE) && (in_lo >= in_hi);

  assign rs = mem_rd_data[2*CW-1:CW];
  assign re = mem_rd_data[CW-1:0];

  assign over = wr_cnt_r > MAX_CNT;

  // Decision for one stored entry against the request.
  always_comb begin
    ev_emit   = 1'b0;
    ev_split  = 1'b0;
    ev_absorb = 1'b0;
    ev_s      = rs;
    ev_e      = re;
    ev_ps     = rs;
    ev_pe     = re;
    case (cmd_r)
      CMD_ADD: begin
        if (ins_r || (rs < lo_r && re < lo_r)) begin
          ev_emit = 1'b1;
        end else if (rs <= mhi_r) begin
          ev_absorb = 1'b1;
        end else begin
          ev_emit  = 1'b1;
          ev_s     = mlo_r;
          ev_e     = mhi_r;
          ev_split = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if ((rs < lo_r && re <= lo_r) || rs >= hi_r) begin
          ev_emit = 1'b1;
        end else if (rs < lo_r) begin
          ev_emit  = 1'b1;
          ev_e     = lo_r;
          ev_split = re > hi_r;
          ev_ps    = hi_r;
        end else if (re > hi_r) begin
          ev_emit = 1'b1;
          ev_s    = hi_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_bad || in_cmd == CMD_NONE) ? ST_FIN : ST_READ;
        end
      end
      ST_READ:  state_nxt = (rd_idx_r == total_r) ? ST_END : ST_EVAL;
      ST_EVAL:  state_nxt = ev_split ? ST_SPLIT : ST_READ;
      ST_SPLIT: state_nxt = ST_READ;
      ST_END:   state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = state_r != ST_IDLE;
    mem_rd_en = state_r == ST_READ;
    emit      = 1'b0;
    emit_s    = plo_r;
    emit_e    = phi_r;
    unique case (state_r)
      ST_EVAL: begin
        emit   = ev_emit && (cmd_r == CMD_ADD || cmd_r == CMD_REMOVE);
        emit_s = ev_s;
        emit_e = ev_e;
      end
      ST_SPLIT: emit = 1'b1;
      ST_END: begin
        emit   = cmd_r == CMD_ADD && !ins_r;
        emit_s = mlo_r;
        emit_e = mhi_r;
      end
      default: begin
      end
    endcase
  end

  // Reads come from the live bank, writes go to the other one.
  assign mem_rd_addr = {bank_r, rd_idx_r[IW-1:0]};
  assign mem_wr_addr = {~bank_r, wr_cnt_r[IW-1:0]};
  assign mem_wr_data = {emit_s, emit_e};
  assign mem_wr_en   = emit && (wr_cnt_r < MAX_CNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == ST_FIN;
      if (state_r == ST_FIN && !bad_r && !over &&
          (cmd_r == CMD_ADD || cmd_r == CMD_REMOVE)) begin
        bank_r  <= ~bank_r;
        total_r <= wr_cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      wr_cnt_r <= wr_cnt_r + 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        cmd_r    <= in_cmd;
        bad_r    <= in_bad;
        lo_r     <= in_lo;
        hi_r     <= in_hi;
        mlo_r    <= in_lo;
        mhi_r    <= in_hi;
        ins_r    <= 1'b0;
        cov_r    <= 1'b0;
        rd_idx_r <= '0;
        wr_cnt_r <= '0;
      end
      ST_EVAL: begin
        rd_idx_r <= rd_idx_r + 1'b1;
        if (ev_absorb) begin
          if (rs < mlo_r) mlo_r <= rs;
          if (re > mhi_r) mhi_r <= re;
        end
        if (cmd_r == CMD_ADD && ev_split) begin
          ins_r <= 1'b1;
        end
        if (cmd_r == CMD_QUERY && rs <= lo_r) begin
          cov_r <= re >= hi_r;
        end
        plo_r <= ev_ps;
        phi_r <= ev_pe;
      end
      ST_FIN: begin
        out_covered_r <= 1'b0;
        out_status_r  <= STAT_OK;
        if (bad_r) begin
          out_status_r <= STAT_BAD;
        end else if (cmd_r == CMD_QUERY) begin
          out_covered_r <= cov_r;
        end else if (cmd_r != CMD_NONE && over) begin
          out_status_r <= STAT_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  assign count_ext       = {{COUNT_W{1'b0}}, total_r};
  assign out_valid       = out_valid_r;
  assign out_covered     = out_covered_r;
  assign out_status      = out_status_r;
  assign out_entry_count = count_ext[COUNT_W-1:0];

endmodule
`default_nettype wire

### design/interval_set_tracker.sv
// Interval set tracker top level: sequencer plus the two-bank table memory.
// Depends on ist_pkg, ist_ctrl and ist_mem.
//
// A request is taken when start is high and busy is low. Add, remove and
// query walk the stored intervals in order. Each stored interval costs one
// memory read and one evaluation. An extra write state follows when a
// remove splits an interval in two, or when an add writes its merged
// interval ahead of a later one. A last read that finds the end, an end
// state and a finish state close the walk. A rejected range or an unused
// command goes straight to the finish state. The single read port of the
// table memory sets the pace. The result shows on out_valid for one cycle,
// the first cycle in which busy is low again. The receiver must take it
// then, because it is not held. No clearing pass is needed after reset.
`default_nettype none
module interval_set_tracker #(
  parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_WIDTH   = ist_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire ist_pkg::cmd_t                  in_cmd,
  input  wire logic [ist_pkg::IN_COORD_W-1:0] in_range_left,
  input  wire logic [ist_pkg::IN_COORD_W-1:0] in_range_right,
  output logic                                out_valid,
  output logic                                out_covered,
  output ist_pkg::status_t                    out_status,
  output logic [ist_pkg::COUNT_W-1:0]         out_entry_count
);
  import ist_pkg::*;

  localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int AW = IW + 1;

  logic                     mem_wr_en, mem_rd_en;
  logic [AW-1:0]            mem_wr_addr, mem_rd_addr;
  logic [2*COORD_WIDTH-1:0] mem_wr_data, mem_rd_data;

  ist_ctrl #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_range_left  (in_range_left),
    .in_range_right (in_range_right),
    .out_valid      (out_valid),
    .out_covered    (out_covered),
    .out_status     (out_status),
    .out_entry_count(out_entry_count),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  ist_mem #(
    .DEPTH(2 ** AW),
    .WIDTH(2 * COORD_WIDTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule
`default_nettype wire

### design/ist_checker.sv
// Port-level checks for the interval set tracker, bound to the top level.
// Depends on ist_pkg.
`default_nettype none
module ist_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           out_valid,
  input wire logic                           out_covered,
  input wire ist_pkg::status_t               out_status
);
  import ist_pkg::*;

  // A request leaves idle before it reaches the finish state, so strobes never touch.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result strobes");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request taken but not busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_FULL ||
                   out_status == STAT_BAD)) else $error("bad status code");

  a_covered_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_covered |-> out_status == STAT_OK)
    else $error("covered with error status");

endmodule

bind interval_set_tracker ist_checker u_ist_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_covered(out_covered),
  .out_status (out_status)
);
`default_nettype wire

### tb/interval_set_tracker_tb.sv
// Testbench for the interval set tracker: drives add, remove and query
// requests and checks every result against an interval table kept here.
// Depends on ist_pkg and the interval_set_tracker RTL.
`default_nettype none
module interval_set_tracker_tb;
  import ist_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t in_cmd = CMD_ADD;
  logic [31:0] in_range_left = '0;
  logic [31:0] in_range_right = '0;
  logic out_valid;
  logic out_covered;
  status_t out_status;
  logic [6:0] out_entry_count;

  interval_set_tracker dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_range_left(in_range_left), .in_range_right(in_range_right),
    .out_valid(out_valid), .out_covered(out_covered), .out_status(out_status),
    .out_entry_count(out_entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic covered;
    status_t status;
    logic [6:0] count;
  } tracker_result_t;

  // Predicted table of disjoint intervals, sorted by start.
  logic [31:0] span_lo [$];
  logic [31:0] span_hi [$];
  tracker_result_t pending_results [$];
  int mismatches = 0;
  bit quiet = 1'b0;

  function automatic status_t predict_add(logic [31:0] lo, logic [31:0] hi);
    int i, j, n;
    n = span_lo.size();
    i = 0;
    while (i < n && span_lo[i] < lo) i++;
    if (i > 0 && span_hi[i-1] >= lo) i--;
    j = i;
    while (j < n && span_lo[j] <= hi) begin
      if (span_lo[j] < lo) lo = span_lo[j];
      if (span_hi[j] > hi) hi = span_hi[j];
      j++;
    end
    if (n - (j - i) + 1 > CAP) return STAT_FULL;
    for (int k = j - 1; k >= i; k--) begin
      span_lo.delete(k);
      span_hi.delete(k);
    end
    span_lo.insert(i, lo);
    span_hi.insert(i, hi);
    return STAT_OK;
  endfunction

  function automatic status_t predict_remove(logic [31:0] lo, logic [31:0] hi);
    int i, j, n, pieces;
    logic [31:0] ps [2];
    logic [31:0] pe [2];
    n = span_lo.size();
    pieces = 0;
    i = 0;
    while (i < n && span_lo[i] < lo) i++;
    if (i > 0 && span_hi[i-1] > lo) i--;
    j = i;
    while (j < n && span_lo[j] < hi) begin
      if (span_lo[j] < lo && pieces < 2) begin
        ps[pieces] = span_lo[j]; pe[pieces] = lo; pieces++;
      end
      if (span_hi[j] > hi && pieces < 2) begin
        ps[pieces] = hi; pe[pieces] = span_hi[j]; pieces++;
      end
      j++;
    end
    if (n - (j - i) + pieces > CAP) return STAT_FULL;
    for (int k = j - 1; k >= i; k--) begin
      span_lo.delete(k);
      span_hi.delete(k);
    end
    for (int k = pieces - 1; k >= 0; k--) begin
      span_lo.insert(i, ps[k]);
      span_hi.insert(i, pe[k]);
    end
    return STAT_OK;
  endfunction

  function automatic tracker_result_t predict_request(cmd_t c, logic [31:0] lo,
                                                     logic [31:0] hi);
    tracker_result_t r;
    int i;
    r = '{covered: 1'b0, status: STAT_OK, count: '0};
    if (c != CMD_NONE && lo >= hi) r.status = STAT_BAD;
    else if (c == CMD_ADD) r.status = predict_add(lo, hi);
    else if (c == CMD_REMOVE) r.status = predict_remove(lo, hi);
    else if (c == CMD_QUERY) begin
      i = 0;
      while (i < span_lo.size() && span_lo[i] <= lo) i++;
      r.covered = (i > 0) && (span_hi[i-1] >= hi);
    end
    r.count = 7'(span_lo.size());
    return r;
  endfunction

  // Sends one request, with occasional idle cycles before it unless quiet is set. The task
  // returns at the edge that takes the request; start stays high into the
  // next request unless an idle cycle drops it.
  task automatic send_request(cmd_t c, logic [31:0] lo, logic [31:0] hi);
    if (!quiet) begin
      while ($urandom_range(99) < 16) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_cmd <= c;
    in_range_left <= lo;
    in_range_right <= hi;
    pending_results = {pending_results, predict_request(c, lo, hi)};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    tracker_result_t got, want;
    if (rst_n && out_valid) begin
      got = '{covered: out_covered, status: out_status, count: out_entry_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic logic [31:0] near_coord(int span);
    return $urandom_range(span);
  endfunction

  task automatic test_directed();
    send_request(CMD_QUERY, 32'd0, 32'd1);
    send_request(CMD_ADD, 32'd10, 32'd10);
    send_request(CMD_REMOVE, 32'd20, 32'd5);
    send_request(CMD_QUERY, 32'hFFFF_FFFF, 32'd0);
    send_request(CMD_ADD, 32'd10, 32'd20);
    send_request(CMD_ADD, 32'd30, 32'd40);
    send_request(CMD_ADD, 32'd20, 32'd30);
    send_request(CMD_QUERY, 32'd10, 32'd40);
    send_request(CMD_QUERY, 32'd9, 32'd40);
    send_request(CMD_REMOVE, 32'd15, 32'd25);
    send_request(CMD_QUERY, 32'd10, 32'd16);
    send_request(CMD_NONE, 32'd0, 32'd100);
    send_request(CMD_ADD, 32'd0, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(CMD_REMOVE, 32'h8000_0000, 32'h8000_0001);
    send_request(CMD_REMOVE, 32'd0, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(CMD_REMOVE, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // Fills the table to capacity, then pushes add and split past it.
  task automatic test_table_full();
    for (int k = 0; k < CAP; k++) send_request(CMD_ADD, 32'(k * 10), 32'(k * 10 + 5));
    send_request(CMD_ADD, 32'd1000, 32'd1001);
    send_request(CMD_REMOVE, 32'd1, 32'd2);
    send_request(CMD_ADD, 32'd3, 32'd4);
    send_request(CMD_ADD, 32'd5, 32'd10);
    send_request(CMD_REMOVE, 32'd1, 32'd2);
    send_request(CMD_QUERY, 32'd630, 32'd635);
    send_request(CMD_REMOVE, 32'd0, 32'hFFFF_FFFF);
  endtask

  // Mostly small coordinates so ranges collide; a few span the whole space.
  task automatic test_random(int count);
    logic [31:0] lo, hi;
    cmd_t c;
    int sel;
    for (int k = 0; k < count; k++) begin
      quiet = (k >= count / 3 && k < count / 2);
      sel = $urandom_range(99);
      if (sel < 45) c = CMD_ADD;
      else if (sel < 70) c = CMD_REMOVE;
      else if (sel < 97) c = CMD_QUERY;
      else c = CMD_NONE;
      if ($urandom_range(19) == 0) begin
        lo = $urandom();
        hi = $urandom();
      end else begin
        lo = near_coord(1500);
        hi = ($urandom_range(9) == 0) ? near_coord(1500) : lo + $urandom_range(1, 60);
      end
      // Clear now and then so the table does not stay saturated.
      if ($urandom_range(299) == 0) begin
        c = CMD_REMOVE; lo = 32'd0; hi = 32'hFFFF_FFFF;
      end
      send_request(c, lo, hi);
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(2000);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
